// ===== rtl/core/jhbd_pkg.sv =====
// Package with the item types, function and status codes, and sizing constants.
package jhbd_pkg;

    localparam int MAX_CODE_LEN   = 16;
    localparam int NUM_SYMBOLS    = 256;
    localparam int RESERVOIR_BITS = 32;
    localparam int LEN_W  = 5;
    localparam int HELD_W = 6;
    localparam int CODE_W = 17;
    localparam int POS_W  = 9;

    typedef enum logic [2:0] {
        FN_LOAD_COUNT  = 3'd0,
        FN_LOAD_SYMBOL = 3'd1,
        FN_BUILD       = 3'd2,
        FN_PUSH        = 3'd3,
        FN_DECODE      = 3'd4,
        FN_READ        = 3'd5,
        FN_PEEK        = 3'd6,
        FN_RESET       = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_CODE   = 3'd1,
        ST_FEW_BITS  = 3'd2,
        ST_BAD_MARK  = 3'd3,
        ST_FULL      = 3'd4,
        ST_RST_HOLD  = 3'd5,
        ST_OVERSUB   = 3'd6,
        ST_TOO_WIDE  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_SCAN,
        S_SYM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] index;
        logic [7:0] value;
        logic [4:0] bit_count;
    } in_item_t;

    typedef struct packed {
        logic [15:0] data;
        logic [4:0]  code_length;
        logic [2:0]  status;
        logic        restart_seen;
    } out_item_t;

endpackage

// ===== rtl/core/jhbd_symbol_ram.sv =====
// Symbol value memory with one write port and a registered read port.
module jhbd_symbol_ram
    import jhbd_pkg::*;
(
    input  logic       clk,
    input  logic       wr_en,
    input  logic [7:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic [7:0] rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0] mem [NUM_SYMBOLS];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/jpeg_huffman_bit_decoder.sv =====
// Top level of the JPEG Huffman bit decoder: sequencer, table and bit reservoir.
// Loads, pushes, reads, peeks and resets go from accept through the output state to the result.
// A decode walks the code lengths one per cycle through a shared compare unit and
// then reads the symbol memory. A table build steps once per length.
// One item is in flight at a time; the result register frees when its item is taken.
// Reset clears the counts, starts, reservoir and flags; the symbol memory is not cleared.
module jpeg_huffman_bit_decoder
    import jhbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [7:0]          counts_reg [MAX_CODE_LEN];
    logic [CODE_W-1:0]   fcode_reg  [MAX_CODE_LEN];
    logic [POS_W-1:0]    fpos_reg   [MAX_CODE_LEN];
    logic [RESERVOIR_BITS-1:0] res_reg;
    logic [HELD_W-1:0]   held_reg;
    logic                ffp_reg, rst_flag_reg;
    logic [3:0]          len_reg;
    logic [18:0]         code_reg;
    logic [11:0]         pos_reg;
    logic [24:0]         used_reg;
    logic [LEN_W-1:0]    clen_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;
    logic [7:0]          ram_rd;
    logic [7:0]          ram_addr;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    wire accept = in_valid && !in_stall;
    wire take   = out_valid_reg && !out_stall;

    // Top 16 bits of the held bits, zero padded at the low end.
    logic [63:0] win64;
    logic [15:0] peek16;
    always_comb
    begin
        win64  = {32'd0, res_reg} << (7'd64 - {1'b0, held_reg});
        peek16 = (held_reg == '0) ? 16'd0 : win64[63:48];
    end

    // Shared compare unit for one code length.
    logic [15:0] code_l;
    logic [16:0] diff;
    logic        hit;
    logic [9:0]  sym_pos;
    always_comb
    begin
        code_l  = peek16 >> (4'd15 - len_reg);
        diff    = {1'b0, code_l} - fcode_reg[len_reg];
        hit     = (counts_reg[len_reg] != 8'd0) && ({1'b0, code_l} >= fcode_reg[len_reg])
                  && (diff < {9'd0, counts_reg[len_reg]});
        sym_pos = {1'b0, fpos_reg[len_reg]} + diff[9:0];
    end

    assign ram_addr = sym_pos[7:0];

    jhbd_symbol_ram u_ram (
        .clk     (clk),
        .wr_en   (accept && in_item.func == FN_LOAD_SYMBOL),
        .wr_addr (in_item.index),
        .wr_data (in_item.value),
        .rd_addr (ram_addr),
        .rd_data (ram_rd)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func_t'(in_item.func))
                        FN_BUILD:  state_next = S_BUILD;
                        FN_DECODE: state_next = S_SCAN;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_BUILD: if (len_reg == 4'd15) state_next = S_OUT;
            S_SCAN:
            begin
                if (hit && sym_pos < 10'(NUM_SYMBOLS)
                    && {2'b0, len_reg} + 6'd1 <= held_reg)
                    state_next = S_SYM;
                else if (hit || len_reg == 4'd15)
                    state_next = S_OUT;
            end
            S_SYM:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Helpers for the read and peek operations.
    logic [4:0]  n;
    logic [63:0] rwin;
    logic [15:0] rbits;
    always_comb
    begin
        n     = item_reg.bit_count;
        rwin  = {32'd0, res_reg} << (7'd64 - {1'b0, held_reg});
        rbits = (n == 5'd0 || n > 5'd16) ? 16'd0 : 16'(rwin[63:48] >> (5'd16 - n));
    end

    // Final result of the item in flight, as loaded in the output state.
    out_item_t fin_item;
    always_comb
    begin
        fin_item = out_reg;
        fin_item.restart_seen = rst_flag_reg;
        unique case (func_t'(item_reg.func))
            FN_LOAD_COUNT, FN_LOAD_SYMBOL:
                fin_item.status = ST_OK;
            FN_PUSH:
            begin
                fin_item.status = ST_OK;
                if (rst_flag_reg)
                    fin_item.status = ST_RST_HOLD;
                else if (ffp_reg)
                begin
                    if (item_reg.value == 8'h00)
                        fin_item.status = ST_OK;
                    else if (item_reg.value >= 8'hD0 && item_reg.value <= 8'hD7)
                        fin_item.restart_seen = 1'b1;
                    else
                        fin_item.status = ST_BAD_MARK;
                end
                else if (held_reg + 6'd8 > 6'(RESERVOIR_BITS))
                    fin_item.status = ST_FULL;
            end
            FN_READ:
            begin
                fin_item.status = ST_OK;
                if (n > 5'd16)
                    fin_item.status = ST_TOO_WIDE;
                else if ({1'b0, n} > held_reg)
                    fin_item.status = ST_FEW_BITS;
                else
                    fin_item.data = rbits;
            end
            FN_PEEK:
            begin
                fin_item.status = (n > 5'd16) ? ST_TOO_WIDE : ST_OK;
                fin_item.data   = rbits;
            end
            FN_RESET:
            begin
                fin_item.status       = ST_OK;
                fin_item.restart_seen = 1'b0;
            end
            default: ;
        endcase
    end

    // Datapath and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            held_reg      <= '0;
            ffp_reg       <= 1'b0;
            rst_flag_reg  <= 1'b0;
            for (int i = 0; i < MAX_CODE_LEN; i++)
            begin
                counts_reg[i] <= '0;
                fcode_reg[i]  <= '0;
                fpos_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= in_item;
                        len_reg  <= '0;
                        code_reg <= '0;
                        pos_reg  <= '0;
                        used_reg <= '0;
                        clen_reg <= '0;
                        out_reg  <= '{data: 16'd0, code_length: 5'd0, status: ST_NO_CODE,
                                     restart_seen: 1'b0};
                        if (in_item.func == FN_LOAD_COUNT && in_item.index < 8'(MAX_CODE_LEN))
                            counts_reg[in_item.index[3:0]] <= in_item.value;
                    end
                end
                S_BUILD:
                begin
                    fcode_reg[len_reg] <= (code_reg > 19'h1FFFF) ? 17'h1FFFF : code_reg[16:0];
                    fpos_reg[len_reg]  <= (pos_reg > 12'(NUM_SYMBOLS)) ? 9'(NUM_SYMBOLS)
                                                                        : pos_reg[8:0];
                    used_reg <= used_reg
                                + 25'({counts_reg[len_reg], 16'd0} >> (5'(len_reg) + 5'd1));
                    pos_reg  <= pos_reg + 12'(counts_reg[len_reg]);
                    if (({1'b0, code_reg} + 20'(counts_reg[len_reg])) > 20'h1FFFF)
                        code_reg <= 19'h3FFFF;
                    else
                        code_reg <= 19'((code_reg + 19'(counts_reg[len_reg])) << 1);
                    len_reg <= len_reg + 4'd1;
                    if (len_reg == 4'd15)
                    begin
                        logic [24:0] u;
                        logic [11:0] p;
                        u = used_reg + 25'(counts_reg[len_reg]);
                        p = pos_reg + 12'(counts_reg[len_reg]);
                        out_reg.status <= (u > 25'h10000 || p > 12'(NUM_SYMBOLS))
                                          ? ST_OVERSUB : ST_OK;
                    end
                end
                S_SCAN:
                begin
                    len_reg <= len_reg + 4'd1;
                    if (hit)
                    begin
                        if (sym_pos >= 10'(NUM_SYMBOLS))
                            out_reg.status <= ST_NO_CODE;
                        else if ({2'b0, len_reg} + 6'd1 > held_reg)
                            out_reg.status <= ST_FEW_BITS;
                        else
                        begin
                            held_reg <= held_reg - ({2'b0, len_reg} + 6'd1);
                            res_reg  <= res_reg & ((RESERVOIR_BITS'(1) <<
                                        (held_reg - ({2'b0, len_reg} + 6'd1))) - 1'b1);
                            clen_reg <= LEN_W'(len_reg) + 5'd1;
                        end
                    end
                end
                S_SYM:
                begin
                    out_reg <= '{data: {8'd0, ram_rd}, code_length: clen_reg, status: ST_OK,
                                 restart_seen: 1'b0};
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= fin_item;
                    unique case (func_t'(item_reg.func))
                        FN_PUSH:
                        begin
                            if (!rst_flag_reg && ffp_reg)
                            begin
                                ffp_reg <= 1'b0;
                                if (item_reg.value == 8'h00)
                                begin
                                    res_reg  <= {res_reg[RESERVOIR_BITS-9:0], 8'hFF};
                                    held_reg <= held_reg + 6'd8;
                                end
                                else if (item_reg.value >= 8'hD0 && item_reg.value <= 8'hD7)
                                    rst_flag_reg <= 1'b1;
                            end
                            else if (!rst_flag_reg
                                     && held_reg + 6'd8 <= 6'(RESERVOIR_BITS))
                            begin
                                if (item_reg.value == 8'hFF)
                                    ffp_reg <= 1'b1;
                                else
                                begin
                                    res_reg  <= {res_reg[RESERVOIR_BITS-9:0], item_reg.value};
                                    held_reg <= held_reg + 6'd8;
                                end
                            end
                        end
                        FN_READ:
                        begin
                            if (n <= 5'd16 && {1'b0, n} <= held_reg)
                            begin
                                held_reg <= held_reg - {1'b0, n};
                                res_reg  <= res_reg & ((RESERVOIR_BITS'(1) <<
                                            (held_reg - {1'b0, n})) - 1'b1);
                            end
                        end
                        FN_RESET:
                        begin
                            res_reg  <= '0;
                            held_reg <= '0;
                            ffp_reg  <= 1'b0;
                            rst_flag_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the JPEG Huffman bit decoder.
`timescale 1ns / 1ps

module tb;
    import jhbd_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    jpeg_huffman_bit_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Decoder state as predicted by the bench.
    logic [7:0]  lens [16];
    logic [7:0]  syms [256];
    bit          sym_written [256];
    logic [16:0] code_start [16];
    logic [8:0]  pos_start [16];
    logic [63:0] resv;
    int unsigned held;
    bit          ff_wait;
    bit          rst_flag;

    out_item_t   pending_results [$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    longint      cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    // Directed table: item and, where known at a glance, the expected result.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } vector_t;

    vector_t     vecs [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] top_of_resv(int unsigned n);
        logic [63:0] v;
        if (n == 0)
            return 32'd0;
        if (held >= n)
            v = resv >> (held - n);
        else
            v = resv << (n - held);
        return v[31:0] & ((32'd1 << n) - 32'd1);
    endfunction

    function automatic void drop_bits(int unsigned n);
        held = held - n;
        resv = resv & ((64'd1 << held) - 64'd1);
    endfunction

    function automatic bit add_byte(logic [7:0] b);
        if (held + 8 > RESERVOIR_BITS)
            return 1'b0;
        resv = ((resv << 8) | b) & ((64'd1 << RESERVOIR_BITS) - 64'd1);
        held = held + 8;
        return 1'b1;
    endfunction

    function automatic status_t build_codes();
        longint code, pos, used;
        longint c;
        used = 0;
        code = 0;
        pos = 0;
        for (int l = 1; l <= MAX_CODE_LEN; l++)
        begin
            c = lens[l-1];
            code_start[l-1] = (code > 'h1FFFF) ? 17'h1FFFF : code[16:0];
            pos_start[l-1] = (pos > NUM_SYMBOLS) ? 9'(NUM_SYMBOLS) : pos[8:0];
            used += c << (MAX_CODE_LEN - l);
            pos += c;
            code = (code + c) << 1;
            if (code > 'h3FFFF)
                code = 'h3FFFF;
        end
        if (used > (longint'(1) << MAX_CODE_LEN) || pos > NUM_SYMBOLS)
            return ST_OVERSUB;
        return ST_OK;
    endfunction

    // Finds the symbol position a decode would read, or -1.
    function automatic int decode_position();
        logic [31:0] pk, c;
        pk = top_of_resv(MAX_CODE_LEN);
        for (int l = 1; l <= MAX_CODE_LEN; l++)
        begin
            c = pk >> (MAX_CODE_LEN - l);
            if (lens[l-1] != 0 && c >= code_start[l-1] && c - code_start[l-1] < lens[l-1])
            begin
                if (pos_start[l-1] + (c - code_start[l-1]) >= NUM_SYMBOLS || l > held)
                    return -1;
                return pos_start[l-1] + (c - code_start[l-1]);
            end
        end
        return -1;
    endfunction

    // Computes the result of one item and updates the predicted state.
    function automatic out_item_t decode_step(in_item_t it);
        out_item_t r;
        logic [31:0] pk, c, p;
        r = '0;
        case (func_t'(it.func))
            FN_LOAD_COUNT:  if (it.index < MAX_CODE_LEN) lens[it.index] = it.value;
            FN_LOAD_SYMBOL:
            begin
                syms[it.index] = it.value;
                sym_written[it.index] = 1'b1;
            end
            FN_BUILD:       r.status = build_codes();
            FN_PUSH:
            begin
                if (rst_flag)
                    r.status = ST_RST_HOLD;
                else if (ff_wait)
                begin
                    ff_wait = 1'b0;
                    if (it.value == 8'h00)
                        void'(add_byte(8'hFF));
                    else if (it.value >= 8'hD0 && it.value <= 8'hD7)
                        rst_flag = 1'b1;
                    else
                        r.status = ST_BAD_MARK;
                end
                else if (it.value == 8'hFF)
                begin
                    if (held + 8 > RESERVOIR_BITS)
                        r.status = ST_FULL;
                    else
                        ff_wait = 1'b1;
                end
                else if (!add_byte(it.value))
                    r.status = ST_FULL;
            end
            FN_DECODE:
            begin
                pk = top_of_resv(MAX_CODE_LEN);
                r.status = ST_NO_CODE;
                for (int l = 1; l <= MAX_CODE_LEN; l++)
                begin
                    c = pk >> (MAX_CODE_LEN - l);
                    if (lens[l-1] != 0 && c >= code_start[l-1]
                        && c - code_start[l-1] < lens[l-1])
                    begin
                        p = pos_start[l-1] + (c - code_start[l-1]);
                        if (p >= NUM_SYMBOLS)
                            break;
                        if (l > held)
                        begin
                            r.status = ST_FEW_BITS;
                            break;
                        end
                        drop_bits(l);
                        r.data = {8'd0, syms[p[7:0]]};
                        r.code_length = 5'(l);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            FN_READ:
            begin
                if (it.bit_count > 16)
                    r.status = ST_TOO_WIDE;
                else if (it.bit_count > held)
                    r.status = ST_FEW_BITS;
                else
                begin
                    r.data = 16'(top_of_resv(it.bit_count));
                    drop_bits(it.bit_count);
                end
            end
            FN_PEEK:
            begin
                if (it.bit_count > 16)
                    r.status = ST_TOO_WIDE;
                else
                    r.data = 16'(top_of_resv(it.bit_count));
            end
            default:
            begin
                resv = '0;
                held = 0;
                ff_wait = 1'b0;
                rst_flag = 1'b0;
            end
        endcase
        r.restart_seen = rst_flag;
        return r;
    endfunction

    function automatic in_item_t mk(func_t f, int idx, int val, int n);
        in_item_t it;
        it.func = f;
        it.index = idx[7:0];
        it.value = val[7:0];
        it.bit_count = n[4:0];
        return it;
    endfunction

    // Appends one expected result to the scoreboard.
    function automatic void expect_result(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Appends one row to the directed table.
    function automatic void add_vec(in_item_t it, bit typed, out_item_t res);
        vector_t v;
        v.item = it;
        v.typed = typed;
        v.result = res;
        vecs.insert(vecs.size(), v);
    endfunction

    // Drives one item and waits for its acceptance; valid stays up for the next item.
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Sends an item whose result comes from the predictor.
    task automatic send_predicted(in_item_t it);
        expect_result(decode_step(it));
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // Random-content stream with well-formed codes; a few marker and error cases.
    task automatic random_item();
        int k;
        k = $urandom_range(99);
        if (k < 30)
        begin
            if ($urandom_range(9) == 0)
                send_predicted(mk(FN_PUSH, $urandom, 8'hFF, $urandom));
            else if (ff_wait)
                send_predicted(mk(FN_PUSH, $urandom,
                    ($urandom_range(3) == 0) ? $urandom : 8'h00, $urandom));
            else
                send_predicted(mk(FN_PUSH, $urandom, $urandom, $urandom));
        end
        else if (k < 55)
        begin
            if (decode_position() < 0 || sym_written[decode_position()])
                send_predicted(mk(FN_DECODE, $urandom, $urandom, $urandom));
            else
                send_predicted(mk(FN_PEEK, $urandom, $urandom, 16));
        end
        else if (k < 70)
            send_predicted(mk(FN_READ, $urandom, $urandom, $urandom_range(17)));
        else if (k < 82)
            send_predicted(mk(FN_PEEK, $urandom, $urandom,
                ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16)));
        else if (k < 88)
            send_predicted(mk(FN_RESET, $urandom, $urandom, $urandom));
        else if (k < 94)
            send_predicted(mk(FN_LOAD_SYMBOL, $urandom, $urandom, $urandom));
        else if (k < 97)
            send_predicted(mk(FN_LOAD_COUNT, $urandom_range(20), $urandom_range(6),
                $urandom));
        else
            send_predicted(mk(FN_BUILD, $urandom, $urandom, $urandom));
    endtask

    // Loads fresh random counts, optionally every symbol, then builds the table.
    task automatic load_table(bit wild, bit with_syms);
        int left;
        left = 256;
        for (int l = 0; l < 16; l++)
        begin
            int c;
            c = wild ? $urandom_range(255) : $urandom_range(l < 8 ? (1 << l) : 4);
            if (!wild && c > left) c = left;
            left -= c;
            send_predicted(mk(FN_LOAD_COUNT, l, c, $urandom));
        end
        if (with_syms)
        begin
            for (int s = 0; s < 256; s++)
                send_predicted(mk(FN_LOAD_SYMBOL, s, $urandom, $urandom));
        end
        send_predicted(mk(FN_BUILD, $urandom, $urandom, $urandom));
    endtask

    // Receiver: random stall and result checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_item);
                end
                else
                begin
                    out_item_t want;
                    want = pending_results.pop_front();
                    if (out_item.data !== want.data
                        || out_item.code_length !== want.code_length
                        || out_item.status !== want.status
                        || out_item.restart_seen !== want.restart_seen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, out_item);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[jpeg_huffman_bit_decoder] ERROR");
            $finish;
        end
    end

    initial
    begin
        out_item_t r;
        int phase;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 16; i++)
        begin
            lens[i] = '0;
            code_start[i] = '0;
            pos_start[i] = '0;
        end
        for (int i = 0; i < 256; i++)
        begin
            syms[i] = '0;
            sym_written[i] = 1'b0;
        end
        resv = '0;
        held = 0;
        ff_wait = 1'b0;
        rst_flag = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: errors on an empty reader, then a small table and markers.
        r = '0;
        add_vec(mk(FN_DECODE, 0, 0, 0), 1, '{16'd0, 5'd0, ST_NO_CODE, 1'b0});
        add_vec(mk(FN_READ, 0, 0, 1), 1, '{16'd0, 5'd0, ST_FEW_BITS, 1'b0});
        add_vec(mk(FN_PEEK, 0, 0, 17), 1, '{16'd0, 5'd0, ST_TOO_WIDE, 1'b0});
        add_vec(mk(FN_READ, 255, 255, 31), 1, '{16'd0, 5'd0, ST_TOO_WIDE, 1'b0});
        add_vec(mk(FN_PEEK, 0, 0, 0), 1, r);
        add_vec(mk(FN_LOAD_COUNT, 16, 9, 0), 1, r);
        add_vec(mk(FN_LOAD_COUNT, 0, 1, 0), 1, r);
        add_vec(mk(FN_LOAD_COUNT, 1, 2, 0), 1, r);
        add_vec(mk(FN_LOAD_SYMBOL, 0, 8'h11, 0), 1, r);
        add_vec(mk(FN_LOAD_SYMBOL, 1, 8'h22, 0), 1, r);
        add_vec(mk(FN_LOAD_SYMBOL, 2, 8'h33, 0), 1, r);
        add_vec(mk(FN_LOAD_SYMBOL, 3, 8'hFF, 0), 1, r);
        add_vec(mk(FN_BUILD, 0, 0, 0), 1, r);
        add_vec(mk(FN_PUSH, 0, 8'h6C, 0), 0, r);
        add_vec(mk(FN_PUSH, 0, 8'hFF, 0), 0, r);
        add_vec(mk(FN_PUSH, 0, 8'h00, 0), 0, r);
        add_vec(mk(FN_DECODE, 0, 0, 0), 0, r);
        add_vec(mk(FN_DECODE, 0, 0, 0), 0, r);
        add_vec(mk(FN_READ, 0, 0, 16), 0, r);
        add_vec(mk(FN_PUSH, 0, 8'hFF, 0), 0, r);
        add_vec(mk(FN_PUSH, 0, 8'h12, 0), 1, '{16'd0, 5'd0, ST_BAD_MARK, 1'b0});
        add_vec(mk(FN_PUSH, 0, 8'hFF, 0), 0, r);
        add_vec(mk(FN_PUSH, 0, 8'hD7, 0), 1, '{16'd0, 5'd0, ST_OK, 1'b1});
        add_vec(mk(FN_PUSH, 0, 8'h00, 0), 1, '{16'd0, 5'd0, ST_RST_HOLD, 1'b1});
        add_vec(mk(FN_RESET, 0, 0, 0), 1, r);
        foreach (vecs[i])
        begin
            out_item_t pred;
            pred = decode_step(vecs[i].item);
            expect_result(vecs[i].typed ? vecs[i].result : pred);
            send_item(vecs[i].item);
        end
        for (int i = 0; i < 5; i++)
            send_predicted(mk(FN_PUSH, 0, 8'hA5, 0));
        send_predicted(mk(FN_PUSH, 0, 8'hFF, 0));

        // Sender pauses until the decoder has answered everything so far.
        wait_drained();

        // Random phases with different idle and stall mixes.
        for (phase = 0; phase < 5; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 4) ? 80 : (phase == 3 ? 10 : 0);
            recv_stall_pct = (phase == 2 || phase == 4) ? 80 : (phase == 3 ? 10 : 0);
            load_table(phase == 4, phase == 0);
            for (int i = 0; i < 65; i++)
                random_item();
            wait_drained();
        end

        $display("Sent %0d items over five idle/stall mixes; %0d results checked.",
            items_sent, results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[jpeg_huffman_bit_decoder] OK");
        else
            $display("[jpeg_huffman_bit_decoder] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/jhbd_pkg.sv
rtl/core/jhbd_symbol_ram.sv
rtl/core/jpeg_huffman_bit_decoder.sv
bench/tb.sv
